// ===== rtl/fgcm_pkg.sv =====
`timescale 1ns / 1ps
package fgcm_pkg;

    localparam int COORD_BITS = 24;
    localparam int MAX_LEVELS = 15;

    // configuration register fields
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE = 2'd3;

    localparam logic [CFG_W-1:0] RST_BASE  = 4'd3;
    localparam logic [CFG_W-1:0] RST_HOLE  = 4'd1;
    localparam logic [CFG_W-1:0] RST_DEPTH = 4'd9;
    localparam logic [CFG_W-1:0] RST_SPACE = 4'd1;

    // divisors run from 0 to 16 (a zero base gives 0), remainders stay below 16
    localparam int DIV_W   = CFG_W + 1;
    localparam int DIGIT_W = CFG_W;
    localparam int LEV_W   = 6;

    // reciprocal multiply: quotient = (q * M) >> SHIFT, exact for q < 2^COORD_BITS
    localparam int SHIFT   = COORD_BITS + DIV_W - 1;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = COORD_BITS + RECIP_W;
    localparam longint unsigned RECIP_ONE = 64'd1 << SHIFT;

    // grid extent saturates at 2^COORD_BITS
    localparam int SPAN_W = COORD_BITS + 1;
    localparam logic [SPAN_W-1:0] SPAN_LIMIT = SPAN_W'(RECIP_ONE >> (DIV_W - 1));

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] qx;
        logic [COORD_BITS-1:0] qy;
        logic                  zx;
        logic                  zy;
        logic                  open;
        logic [SPAN_W-1:0]     span;
    } t_lane;

    typedef struct packed {
        logic               active;
        logic               holes;
        logic [CFG_W-1:0]   base;
        logic [CFG_W-1:0]   first_d;
        logic [CFG_W:0]     last_d;
    } t_lvl_ctl;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [DIV_W-1:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            5'd1:    m = RECIP_W'(RECIP_ONE);
            5'd2:    m = RECIP_W'((RECIP_ONE + 64'd1) / 64'd2);
            5'd3:    m = RECIP_W'((RECIP_ONE + 64'd2) / 64'd3);
            5'd4:    m = RECIP_W'((RECIP_ONE + 64'd3) / 64'd4);
            5'd5:    m = RECIP_W'((RECIP_ONE + 64'd4) / 64'd5);
            5'd6:    m = RECIP_W'((RECIP_ONE + 64'd5) / 64'd6);
            5'd7:    m = RECIP_W'((RECIP_ONE + 64'd6) / 64'd7);
            5'd8:    m = RECIP_W'((RECIP_ONE + 64'd7) / 64'd8);
            5'd9:    m = RECIP_W'((RECIP_ONE + 64'd8) / 64'd9);
            5'd10:   m = RECIP_W'((RECIP_ONE + 64'd9) / 64'd10);
            5'd11:   m = RECIP_W'((RECIP_ONE + 64'd10) / 64'd11);
            5'd12:   m = RECIP_W'((RECIP_ONE + 64'd11) / 64'd12);
            5'd13:   m = RECIP_W'((RECIP_ONE + 64'd12) / 64'd13);
            5'd14:   m = RECIP_W'((RECIP_ONE + 64'd13) / 64'd14);
            5'd15:   m = RECIP_W'((RECIP_ONE + 64'd14) / 64'd15);
            5'd16:   m = RECIP_W'((RECIP_ONE + 64'd15) / 64'd16);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/fgcm_if.sv =====
`timescale 1ns / 1ps
interface fgcm_in_if import fgcm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    modport source (output valid, col, row, input ready);
    modport sink   (input valid, col, row, output ready);
endinterface

interface fgcm_out_if;
    logic valid;
    logic ready;
    logic open_cell;
    logic outside_grid;
    logic bad_settings;
    modport source (output valid, open_cell, outside_grid, bad_settings, input ready);
    modport sink   (input valid, open_cell, outside_grid, bad_settings, output ready);
endinterface

// ===== rtl/fractal_grid_cell_mask.sv =====
`timescale 1ns / 1ps
// Pipeline: the front lattice-remainder unit, the fractal levels, then the output register.
// Throughput: one coordinate pair per cycle unless o_out.ready stalls the pipeline; each
// level is a reciprocal-multiply stage and a remainder stage, so without a stall a new item enters every cycle.
// Reset (synchronous, active low) empties the pipeline and loads the register
// defaults: base 3, hole 1, depth 9, spacing 1.
module fractal_grid_cell_mask import fgcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    fgcm_in_if.sink              i_in,
    fgcm_out_if.source           o_out
);
    logic [CFG_W-1:0] r_base;
    logic [CFG_W-1:0] r_hole;
    logic [CFG_W-1:0] r_depth;
    logic [CFG_W-1:0] r_space;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RST_BASE;
            r_hole  <= RST_HOLE;
            r_depth <= RST_DEPTH;
            r_space <= RST_SPACE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE:  r_base  <= i_cfg_data;
                CFG_HOLE:  r_hole  <= i_cfg_data;
                CFG_DEPTH: r_depth <= i_cfg_data;
                CFG_SPACE: r_space <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // settings derived from the registers
    logic             bad;
    logic [DIV_W-1:0] pitch;
    logic [LEV_W-1:0] levels;
    logic [CFG_W-1:0] first_d;
    logic [CFG_W-1:0] band;
    logic [CFG_W:0]   last_d;

    always_comb begin
        bad = ((r_hole != '0) && (r_base[0] != r_hole[0]))
              || (r_base == r_hole) || (r_hole > r_base);
        pitch   = {1'b0, r_space} + DIV_W'(1);
        levels  = (LEV_W'(r_depth) > LEV_W'(MAX_LEVELS)) ? LEV_W'(MAX_LEVELS)
                                                           : LEV_W'(r_depth);
        band    = r_base - r_hole;
        first_d = band >> 1;
        last_d  = {1'b0, first_d} + {1'b0, r_hole} - (CFG_W+1)'(1);
    end

    // split off the lattice remainder
    t_lane              in_lane;
    t_lane              fr_lane;
    logic               fr_valid;
    logic [DIGIT_W-1:0] fr_rx;
    logic [DIGIT_W-1:0] fr_ry;

    always_comb begin
        in_lane      = '0;
        in_lane.x    = i_in.col;
        in_lane.y    = i_in.row;
        in_lane.qx   = i_in.col;
        in_lane.qy   = i_in.row;
    end

    logic  lv_valid [MAX_LEVELS+1];
    logic  lv_ready [MAX_LEVELS+1];
    t_lane lv_lane  [MAX_LEVELS+1];

    fgcm_digit u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_lane  (in_lane),
        .i_div   (pitch),
        .o_valid (fr_valid),
        .i_ready (lv_ready[0]),
        .o_lane  (fr_lane),
        .o_rem_x (fr_rx),
        .o_rem_y (fr_ry)
    );

    // close lattice vertices, seed the zero tracking and the grid extent
    always_comb begin
        lv_valid[0]     = fr_valid;
        lv_lane[0]      = fr_lane;
        lv_lane[0].zx   = (fr_rx == '0);
        lv_lane[0].zy   = (fr_ry == '0);
        lv_lane[0].open = !((fr_rx == '0) && (fr_ry == '0));
        lv_lane[0].span = SPAN_W'(pitch);
    end

    // one stage pair per fractal level
    for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_level
        t_lvl_ctl ctl;
        always_comb begin
            ctl.active  = LEV_W'(k) < levels;
            ctl.holes   = (LEV_W'(k) < levels) && (r_hole != '0);
            ctl.base    = r_base;
            ctl.first_d = first_d;
            ctl.last_d  = last_d;
        end
        fgcm_level u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (lv_valid[k]),
            .o_ready (lv_ready[k]),
            .i_lane  (lv_lane[k]),
            .i_ctl   (ctl),
            .o_valid (lv_valid[k+1]),
            .i_ready (lv_ready[k+1]),
            .o_lane  (lv_lane[k+1])
        );
    end

    // flags and output register
    fgcm_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (lv_valid[MAX_LEVELS]),
        .o_ready   (lv_ready[MAX_LEVELS]),
        .i_lane    (lv_lane[MAX_LEVELS]),
        .i_bad     (bad),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_open    (o_out.open_cell),
        .o_outside (o_out.outside_grid),
        .o_bad     (o_out.bad_settings)
    );
endmodule

// ===== rtl/fgcm_digit.sv =====
`timescale 1ns / 1ps
module fgcm_digit import fgcm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_lane              i_lane,
    input  logic [DIV_W-1:0]   i_div,
    output logic               o_valid,
    input  logic               i_ready,
    output t_lane              o_lane,
    output logic [DIGIT_W-1:0] o_rem_x,
    output logic [DIGIT_W-1:0] o_rem_y
);
    logic              r_a_valid;
    t_lane             r_a_lane;
    logic [PROD_W-1:0] r_a_prod_x;
    logic [PROD_W-1:0] r_a_prod_y;
    logic              r_b_valid;
    t_lane             r_b_lane;
    logic [DIGIT_W-1:0] r_b_rem_x;
    logic [DIGIT_W-1:0] r_b_rem_y;

    logic a_ready;
    logic b_ready;
    logic [COORD_BITS-1:0] quot_x;
    logic [COORD_BITS-1:0] quot_y;
    logic [2*DIV_W-1:0]    back_x;
    logic [2*DIV_W-1:0]    back_y;
    logic [DIV_W-1:0]      rem_x;
    logic [DIV_W-1:0]      rem_y;
    logic [RECIP_W-1:0]    recip;
    t_lane                 n_b_lane;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign recip   = recip_of(i_div);

    // multiply by the reciprocal of the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
        if (a_ready && i_valid) begin
            r_a_lane   <= i_lane;
            r_a_prod_x <= PROD_W'(i_lane.qx) * PROD_W'(recip);
            r_a_prod_y <= PROD_W'(i_lane.qy) * PROD_W'(recip);
        end
    end

    // take the quotient and recover the remainder from the low bits
    always_comb begin
        quot_x = r_a_prod_x[SHIFT +: COORD_BITS];
        quot_y = r_a_prod_y[SHIFT +: COORD_BITS];
        back_x = quot_x[DIV_W-1:0] * i_div;
        back_y = quot_y[DIV_W-1:0] * i_div;
        rem_x  = r_a_lane.qx[DIV_W-1:0] - back_x[DIV_W-1:0];
        rem_y  = r_a_lane.qy[DIV_W-1:0] - back_y[DIV_W-1:0];
        n_b_lane    = r_a_lane;
        n_b_lane.qx = quot_x;
        n_b_lane.qy = quot_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (b_ready && r_a_valid) begin
            r_b_lane  <= n_b_lane;
            r_b_rem_x <= rem_x[DIGIT_W-1:0];
            r_b_rem_y <= rem_y[DIGIT_W-1:0];
        end
    end

    assign o_valid = r_b_valid;
    assign o_lane  = r_b_lane;
    assign o_rem_x = r_b_rem_x;
    assign o_rem_y = r_b_rem_y;
endmodule

// ===== rtl/fgcm_level.sv =====
`timescale 1ns / 1ps
module fgcm_level import fgcm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_lane    i_lane,
    input  t_lvl_ctl i_ctl,
    output logic     o_valid,
    input  logic     i_ready,
    output t_lane    o_lane
);
    t_lane              dig_lane;
    logic [DIGIT_W-1:0] dig_x;
    logic [DIGIT_W-1:0] dig_y;
    logic               hit_x;
    logic               hit_y;
    logic [SPAN_W+CFG_W-1:0] span_prod;

    fgcm_digit u_digit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_lane  (i_lane),
        .i_div   ({1'b0, i_ctl.base}),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_lane  (dig_lane),
        .o_rem_x (dig_x),
        .o_rem_y (dig_y)
    );

    // test this level's digit against the hole band, grow the grid extent
    always_comb begin
        hit_x = (dig_x >= i_ctl.first_d) && ({1'b0, dig_x} <= i_ctl.last_d)
                && !((dig_x == i_ctl.first_d) && dig_lane.zx);
        hit_y = (dig_y >= i_ctl.first_d) && ({1'b0, dig_y} <= i_ctl.last_d)
                && !((dig_y == i_ctl.first_d) && dig_lane.zy);
        span_prod = (SPAN_W+CFG_W)'(dig_lane.span) * (SPAN_W+CFG_W)'(i_ctl.base);
        o_lane = dig_lane;
        if (i_ctl.active) begin
            o_lane.zx = dig_lane.zx && (dig_x == '0);
            o_lane.zy = dig_lane.zy && (dig_y == '0);
            if (span_prod >= (SPAN_W+CFG_W)'(SPAN_LIMIT)) begin
                o_lane.span = SPAN_LIMIT;
            end else begin
                o_lane.span = span_prod[SPAN_W-1:0];
            end
            if (i_ctl.holes && hit_x && hit_y) begin
                o_lane.open = 1'b0;
            end
        end
    end
endmodule

// ===== rtl/fgcm_out.sv =====
`timescale 1ns / 1ps
module fgcm_out import fgcm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_lane i_lane,
    input  logic  i_bad,
    output logic  o_valid,
    input  logic  i_ready,
    output logic  o_open,
    output logic  o_outside,
    output logic  o_bad
);
    logic r_valid;
    logic r_open;
    logic r_outside;
    logic r_bad;
    logic outside;

    assign o_ready = !r_valid || i_ready;
    assign outside = (i_lane.span >= SPAN_LIMIT)
                     || ({1'b0, i_lane.x} > i_lane.span)
                     || ({1'b0, i_lane.y} > i_lane.span);

    // hold the result until the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_open    <= i_lane.open && !outside && !i_bad;
            r_outside <= outside;
            r_bad     <= i_bad;
        end
    end

    assign o_valid   = r_valid;
    assign o_open    = r_open;
    assign o_outside = r_outside;
    assign o_bad     = r_bad;
endmodule

// ===== sim/fgcm_checker.sv =====
`timescale 1ns / 1ps
module fgcm_checker import fgcm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    fgcm_in_if              i_in,
    fgcm_out_if             i_out,
    output int              o_fail_count,
    output int              o_pending
);

    typedef struct packed {
        logic open_cell;
        logic outside_grid;
        logic bad_settings;
    } t_cell_class;

    logic [CFG_W-1:0] base_q, hole_q, depth_q, space_q;
    t_cell_class pending_cells[$];
    int fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cells.size();

    // classify one coordinate pair under the current register settings
    function automatic t_cell_class classify_cell(input logic [COORD_BITS-1:0] col,
                                                  input logic [COORD_BITS-1:0] row);
        t_cell_class res;
        longint unsigned b, l, c1, lev, lim, span, p, period, start, side, mx, my;
        b   = base_q;
        l   = hole_q;
        c1  = space_q + 1;
        lev = (depth_q > MAX_LEVELS) ? MAX_LEVELS : depth_q;
        lim = 64'd1 << COORD_BITS;
        span = c1;
        res.bad_settings = (l != 0 && b[0] != l[0]) || b == l || l > b;
        for (int k = 0; k < lev; k++) begin
            span = span * b;
            if (span >= lim) span = lim;
        end
        res.outside_grid = span >= lim || col > span || row > span;
        res.open_cell = 1'b0;
        if (!res.bad_settings && !res.outside_grid) begin
            res.open_cell = !((col % c1) == 0 && (row % c1) == 0);
            p = c1;
            for (int k = 1; k <= lev; k++) begin
                period = b * p;
                start  = ((b - l) / 2) * p + 1;
                if (l != 0) begin
                    side = l * p - 1;
                    mx = col % period;
                    my = row % period;
                    if (mx >= start && mx < start + side && my >= start && my < start + side)
                        res.open_cell = 1'b0;
                end
                p = period;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("mismatch %s: got %0b expected %0b at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // track registers, predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        t_cell_class want;
        if (!i_rst_n) begin
            base_q  <= RST_BASE;
            hole_q  <= RST_HOLE;
            depth_q <= RST_DEPTH;
            space_q <= RST_SPACE;
            pending_cells.delete();
            fail_count = 0;
        end else begin
            if (i_in.valid && i_in.ready)
                pending_cells.push_back(classify_cell(i_in.col, i_in.row));
            if (i_out.valid && i_out.ready) begin
                if (pending_cells.size() == 0) begin
                    // a result transfer with nothing predicted
                    report_mismatch("result valid", 1'b1, 1'b0);
                end else begin
                    want = pending_cells.pop_front();
                    if (i_out.open_cell !== want.open_cell)
                        report_mismatch("open_cell", i_out.open_cell, want.open_cell);
                    if (i_out.outside_grid !== want.outside_grid)
                        report_mismatch("outside_grid", i_out.outside_grid,
                                        want.outside_grid);
                    if (i_out.bad_settings !== want.bad_settings)
                        report_mismatch("bad_settings", i_out.bad_settings,
                                        want.bad_settings);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE:  base_q  <= i_cfg_data;
                    CFG_HOLE:  hole_q  <= i_cfg_data;
                    CFG_DEPTH: depth_q <= i_cfg_data;
                    CFG_SPACE: space_q <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import fgcm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2 * MAX_LEVELS + 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_BASE;
    logic [CFG_W-1:0] i_cfg_data = '0;

    fgcm_in_if  cell_in ();
    fgcm_out_if cell_out ();

    int fail_count, pending;
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_off = 1'b0;
    int quiet_cycles = 0;
    logic [COORD_BITS-1:0] grid_span;

    fractal_grid_cell_mask dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(cell_in), .o_out(cell_out)
    );

    fgcm_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(cell_in), .i_out(cell_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        cell_in.valid = 1'b0;
        cell_in.col   = '0;
        cell_in.row   = '0;
        cell_out.ready = 1'b0;
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        cell_out.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((cell_in.valid && cell_in.ready) || (cell_out.valid && cell_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // offer one coordinate pair and hold it until transferred
    task automatic send_cell(input logic [COORD_BITS-1:0] col,
                             input logic [COORD_BITS-1:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            cell_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_in.valid <= 1'b1;
        cell_in.col   <= col;
        cell_in.row   <= row;
        @(posedge i_clk);
        while (!cell_in.ready) @(posedge i_clk);
    endtask

    task automatic drain_pipe();
        cell_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_settings(input int b, input int l, input int d, input int c);
        longint unsigned s;
        write_reg(CFG_BASE, CFG_W'(b));
        write_reg(CFG_HOLE, CFG_W'(l));
        write_reg(CFG_DEPTH, CFG_W'(d));
        write_reg(CFG_SPACE, CFG_W'(c));
        @(posedge i_clk);
        s = c + 1;
        for (int k = 0; k < d; k++) if (s < (64'd1 << COORD_BITS)) s = s * b;
        grid_span = (s >= (64'd1 << COORD_BITS)) ? '1 : COORD_BITS'(s);
    endtask

    // mostly coordinates inside the grid, some at its edge and beyond
    function automatic logic [COORD_BITS-1:0] pick_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7) return COORD_BITS'($urandom_range(grid_span));
        if (sel == 7) return grid_span + COORD_BITS'($urandom_range(1));
        return COORD_BITS'($urandom);
    endfunction

    task automatic random_burst(input int count);
        for (int i = 0; i < count; i++) send_cell(pick_coord(), pick_coord());
    endtask

    initial begin
        int settings[8][4];
        settings = '{'{3, 1, 4, 1}, '{5, 1, 3, 0}, '{5, 3, 2, 2}, '{15, 1, 2, 0},
                     '{1, 1, 3, 15}, '{4, 2, 15, 15}, '{7, 3, 1, 15}, '{9, 5, 3, 1}};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, origin, far corners beyond the grid
        grid_span = '1;
        send_cell('0, '0);
        send_cell('1, '1);
        send_cell('1, '0);
        drain_pipe();
        load_settings(3, 1, 2, 1);
        send_cell(0, 0); send_cell(1, 0); send_cell(2, 2); send_cell(3, 3);
        send_cell(4, 4); send_cell(7, 7); send_cell(18, 18); send_cell(19, 0);
        send_cell(0, 19); send_cell(10, 10);
        drain_pipe();
        // bad settings: parity, b == l, l > b, zero base; then no holes, deep levels
        load_settings(4, 1, 2, 1); send_cell(1, 2);
        drain_pipe();
        load_settings(3, 3, 2, 1); send_cell(1, 2);
        drain_pipe();
        load_settings(3, 5, 2, 1); send_cell(1, 2);
        drain_pipe();
        load_settings(0, 0, 2, 1); send_cell(1, 2);
        drain_pipe();
        load_settings(3, 0, 2, 1); send_cell(4, 4); send_cell(3, 3);
        drain_pipe();
        load_settings(1, 1, 15, 0); send_cell(0, 1);
        drain_pipe();

        // random phases over several settings and idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            load_settings(settings[ph][0], settings[ph][1], settings[ph][2], settings[ph][3]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            if (ph == 2) begin
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_off <= 1'b0;
                    end
                    random_burst(120);
                join
                random_burst(100);
            end else begin
                random_burst(220);
            end
            // pause the sender until everything has come back
            drain_pipe();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fgcm_pkg.sv
rtl/fgcm_if.sv
rtl/fgcm_digit.sv
rtl/fgcm_level.sv
rtl/fgcm_out.sv
rtl/fractal_grid_cell_mask.sv
sim/fgcm_checker.sv
sim/tb_top.sv
